FILE: sv/char_lcd_controller_4bit_macros.svh
// Assertion macros used by the character LCD controller checker.
`ifndef CHAR_LCD_CONTROLLER_4BIT_MACROS_SVH
`define CHAR_LCD_CONTROLLER_4BIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: sv/clcd_pkg.sv
// Types and constants shared by the character LCD controller modules.
package clcd_pkg;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_RW       = 3'd1;
  localparam logic [2:0] ST_DATA_READ   = 3'd2;
  localparam logic [2:0] ST_BAD_INSTR   = 3'd3;
  localparam logic [2:0] ST_RESET_ORDER = 3'd4;
  localparam logic [2:0] ST_EIGHT_BIT   = 3'd5;
  localparam logic [2:0] ST_BAD_PORT    = 3'd6;

  // Port commands and port numbers.
  localparam logic       CMD_LATCH = 1'b0;
  localparam logic [2:0] PORT_NULL = 3'd1;
  localparam logic [2:0] PORT_LCD  = 3'd2;

  // Instruction codes and decode masks.
  localparam logic [7:0] INS_RESET_START = 8'h33;
  localparam logic [7:0] INS_RESET_END   = 8'h32;
  localparam logic [7:0] INS_CLEAR       = 8'h01;
  localparam logic [7:0] MSK_FUNC_SET    = 8'hE0;
  localparam logic [7:0] VAL_FUNC_SET    = 8'h20;
  localparam logic [7:0] MSK_DISP_CTRL   = 8'hF8;
  localparam logic [7:0] VAL_DISP_CTRL   = 8'h08;
  localparam logic [7:0] MSK_HOME        = 8'hFE;
  localparam logic [7:0] VAL_HOME        = 8'h02;
  localparam logic [7:0] MSK_SET_ADDR    = 8'hC0;
  localparam logic [7:0] VAL_SET_ADDR    = 8'h40;
  localparam logic [7:0] SET_ADDR_BITS   = 8'h3F;

  localparam logic [7:0] CHAR_BLANK = 8'h20;
  localparam logic [7:0] READ_IDLE  = 8'hFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the incoming beat
    logic commit;      // update state and load the result register
    logic sweep_step;  // write one fill entry of the display RAM
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_hit;   // the pending item is a clear display instruction
    logic sweep_last;  // the fill sweep is at its last entry
  } stat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] status;
    logic       ram_written;
    logic [6:0] ram_write_address;
    logic [7:0] ram_write_char;
    logic [6:0] address_counter_now;
    logic [2:0] busy_now;
    logic       display_enabled;
    logic       cursor_enabled;
    logic       blink_enabled;
    logic       two_line_mode;
    logic       entry_increments;
  } result_t;

endpackage

FILE: sv/clcd_if.sv
// Valid/ready channel interfaces for port accesses and their results.
interface clcd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [2:0] port_number;
  logic [7:0] bus_byte;

  modport source (output valid, command, port_number, bus_byte, input ready);
  modport sink (input valid, command, port_number, bus_byte, output ready);
endinterface

interface clcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [2:0] status;
  logic       ram_written;
  logic [6:0] ram_write_address;
  logic [7:0] ram_write_char;
  logic [6:0] address_counter_now;
  logic [2:0] busy_now;
  logic       display_enabled;
  logic       cursor_enabled;
  logic       blink_enabled;
  logic       two_line_mode;
  logic       entry_increments;

  modport source (
    output valid, read_data, status, ram_written, ram_write_address, ram_write_char,
           address_counter_now, busy_now, display_enabled, cursor_enabled,
           blink_enabled, two_line_mode, entry_increments,
    input  ready
  );
  modport sink (
    input  valid, read_data, status, ram_written, ram_write_address, ram_write_char,
           address_counter_now, busy_now, display_enabled, cursor_enabled,
           blink_enabled, two_line_mode, entry_increments,
    output ready
  );
endinterface

FILE: sv/char_lcd_controller_4bit.sv
// Top level of the 4-bit character LCD controller.
//
// in_i carries one port access per beat: command (latch or read), port_number
// and bus_byte. out_o carries one result beat per access: read data, status,
// any display RAM write, and the address counter, busy count and mode flags
// after the access.
// An access is captured when accepted and executed from the S_EXEC state once the
// result register is free; the result beat becomes valid then, and unless the access
// was a clear display instruction in_i is ready again in that same cycle, so the
// block takes no new access before the last one has executed.
// A clear display instruction fills the RAM_DEPTH-entry display RAM with
// blanks through its single write port, one entry per cycle; in_i stays not
// ready until the sweep has written its last entry.
// After reset all controller state is cleared and the RAM is filled with zeros
// by the same sweep, so in_i first becomes ready once that sweep has written
// its last entry.
// The result is held in an output register; if out_o stalls, the next access
// is still accepted, then waits to execute until the held beat is taken.
module char_lcd_controller_4bit #(
  parameter int RAM_DEPTH = 80
) (
  input  logic clk_i,
  input  logic rst_ni,
  clcd_in_if.sink    in_i,
  clcd_out_if.source out_o
);
  import clcd_pkg::*;

  ctrl_t   ctrl;
  stat_t   stat;
  result_t res;

  clcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .ctrl_o      (ctrl)
  );

  clcd_datapath #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .command_i     (in_i.command),
    .port_number_i (in_i.port_number),
    .bus_byte_i    (in_i.bus_byte),
    .stat_o        (stat),
    .res_o         (res)
  );

  assign out_o.read_data           = res.read_data;
  assign out_o.status              = res.status;
  assign out_o.ram_written         = res.ram_written;
  assign out_o.ram_write_address   = res.ram_write_address;
  assign out_o.ram_write_char      = res.ram_write_char;
  assign out_o.address_counter_now = res.address_counter_now;
  assign out_o.busy_now            = res.busy_now;
  assign out_o.display_enabled     = res.display_enabled;
  assign out_o.cursor_enabled      = res.cursor_enabled;
  assign out_o.blink_enabled       = res.blink_enabled;
  assign out_o.two_line_mode       = res.two_line_mode;
  assign out_o.entry_increments    = res.entry_increments;

endmodule

FILE: sv/clcd_datapath.sv
// Datapath: port lines, nibble assembly, instruction decode, state and display RAM.
module clcd_datapath #(
  parameter int RAM_DEPTH = 80
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  clcd_pkg::ctrl_t  ctrl_i,
  input  logic             command_i,
  input  logic [2:0]       port_number_i,
  input  logic [7:0]       bus_byte_i,
  output clcd_pkg::stat_t  stat_o,
  output clcd_pkg::result_t res_o
);
  import clcd_pkg::*;

  localparam int AW = $clog2(RAM_DEPTH);
  localparam logic [7:0] DEPTH8 = 8'(RAM_DEPTH);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(RAM_DEPTH - 1);

  // Captured beat.
  logic       cmd_q;
  logic [2:0] port_q;
  logic [7:0] bus_q;

  // Controller state.
  logic [7:0] ir_q, ir_d;
  logic [7:0] dr_q, dr_d;
  logic       rs_q, rs_d, rw_q, rw_d, e_q, e_d;
  logic [6:0] ac_q, ac_d;
  logic       lines_q, lines_d;
  logic [3:0] flags_q, flags_d;
  logic       lnn_q, lnn_d;
  logic [7:0] rcnt_q, rcnt_d;
  logic [2:0] busy_q, busy_d;

  // Fill sweep.
  logic [AW-1:0] sweep_q;
  logic [7:0]    fill_q;

  logic [7:0] ram_q [RAM_DEPTH];

  logic       clear_hit;
  logic       rise;
  logic [7:0] ac_inc;
  logic [7:0] set_addr;
  result_t    res_d, res_q;

  always_comb begin
    ir_d      = ir_q;
    dr_d      = dr_q;
    rs_d      = rs_q;
    rw_d      = rw_q;
    e_d       = e_q;
    ac_d      = ac_q;
    lines_d   = lines_q;
    flags_d   = flags_q;
    lnn_d     = lnn_q;
    rcnt_d    = rcnt_q;
    busy_d    = busy_q;
    clear_hit = 1'b0;
    rise      = 1'b0;
    ac_inc    = {1'b0, ac_q} + 8'd1;
    set_addr  = ir_q & SET_ADDR_BITS;
    res_d     = '0;
    res_d.status = ST_OK;

    if (cmd_q == CMD_LATCH) begin
      if (port_q == PORT_NULL) begin
        res_d.status = ST_OK;
      end else if (port_q != PORT_LCD) begin
        res_d.status = ST_BAD_PORT;
      end else begin
        rise = !e_q && bus_q[5];
        rs_d = bus_q[7];
        rw_d = bus_q[6];
        e_d  = bus_q[5];
        if (bus_q[7] && bus_q[6]) begin
          res_d.status = ST_DATA_READ;
        end else if (rise) begin
          if (bus_q[7]) begin
            dr_d = lnn_q ? {dr_q[7:4], bus_q[3:0]} : {bus_q[3:0], dr_q[3:0]};
          end else if (!bus_q[6]) begin
            ir_d = lnn_q ? {ir_q[7:4], bus_q[3:0]} : {bus_q[3:0], ir_q[3:0]};
          end
          lnn_d = !lnn_q;
          set_addr = ir_d & SET_ADDR_BITS;
          // The second nibble completes a byte.
          if (lnn_q) begin
            if (bus_q[7]) begin
              res_d.ram_written       = 1'b1;
              res_d.ram_write_address = ac_q;
              res_d.ram_write_char    = dr_d;
              if (flags_q[3]) begin
                ac_d = (ac_inc < DEPTH8) ? ac_inc[6:0] : 7'd0;
              end else begin
                ac_d = (ac_q == 7'd0) ? 7'd0 : ac_q - 7'd1;
              end
              busy_d = 3'd1;
            end else if (bus_q[6]) begin
              if (busy_q != 3'd0) begin
                busy_d = busy_q - 3'd1;
              end
            end else begin
              if (ir_d == INS_RESET_START) begin
                if (rcnt_q != 8'hFF) begin
                  rcnt_d = rcnt_q + 8'd1;
                end
              end else if (ir_d == INS_RESET_END) begin
                if (rcnt_q != 8'd1 || busy_q != 3'd0) begin
                  res_d.status = ST_RESET_ORDER;
                end else begin
                  rcnt_d = 8'd0;
                  busy_d = 3'd4;
                end
              end else if ((ir_d & MSK_FUNC_SET) == VAL_FUNC_SET) begin
                if (ir_d[4]) begin
                  res_d.status = ST_EIGHT_BIT;
                end else begin
                  lines_d = ir_d[3];
                  busy_d  = 3'd3;
                end
              end else if ((ir_d & MSK_DISP_CTRL) == VAL_DISP_CTRL) begin
                flags_d = {flags_q[3], ir_d[0], ir_d[1], ir_d[2]};
                busy_d  = 3'd1;
              end else if ((ir_d & MSK_HOME) == VAL_HOME) begin
                ac_d   = 7'd0;
                busy_d = 3'd5;
              end else if (ir_d == INS_CLEAR) begin
                ac_d       = 7'd0;
                flags_d[3] = 1'b1;
                busy_d     = 3'd5;
                clear_hit  = 1'b1;
              end else if ((ir_d & MSK_SET_ADDR) == VAL_SET_ADDR) begin
                ac_d   = (set_addr < DEPTH8) ? set_addr[6:0] : 7'd0;
                busy_d = 3'd2;
              end else begin
                res_d.status = ST_BAD_INSTR;
              end
            end
          end
        end
      end
    end else begin
      if (port_q != PORT_LCD) begin
        res_d.status = ST_BAD_PORT;
      end else if (!e_q) begin
        res_d.read_data = READ_IDLE;
      end else if (!rw_q) begin
        res_d.status = ST_NO_RW;
      end else if (rs_q) begin
        res_d.status = ST_DATA_READ;
      end else if (lnn_q) begin
        res_d.read_data = {busy_q != 3'd0, 3'd0, busy_q != 3'd0, ac_q[6:4]};
      end else begin
        res_d.read_data = {4'd0, ac_q[3:0]};
      end
    end

    res_d.address_counter_now = ac_d;
    res_d.busy_now            = busy_d;
    res_d.display_enabled     = flags_d[0];
    res_d.cursor_enabled      = flags_d[1];
    res_d.blink_enabled       = flags_d[2];
    res_d.two_line_mode       = lines_d;
    res_d.entry_increments    = flags_d[3];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q  <= command_i;
      port_q <= port_number_i;
      bus_q  <= bus_byte_i;
    end
    if (ctrl_i.commit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_q    <= '0;
      dr_q    <= '0;
      rs_q    <= 1'b0;
      rw_q    <= 1'b0;
      e_q     <= 1'b0;
      ac_q    <= '0;
      lines_q <= 1'b0;
      flags_q <= '0;
      lnn_q   <= 1'b0;
      rcnt_q  <= '0;
      busy_q  <= '0;
      sweep_q <= '0;
      fill_q  <= '0;
    end else begin
      if (ctrl_i.commit) begin
        ir_q    <= ir_d;
        dr_q    <= dr_d;
        rs_q    <= rs_d;
        rw_q    <= rw_d;
        e_q     <= e_d;
        ac_q    <= ac_d;
        lines_q <= lines_d;
        flags_q <= flags_d;
        lnn_q   <= lnn_d;
        rcnt_q  <= rcnt_d;
        busy_q  <= busy_d;
        if (clear_hit) begin
          sweep_q <= '0;
          fill_q  <= CHAR_BLANK;
        end
      end else if (ctrl_i.sweep_step) begin
        sweep_q <= (sweep_q == LAST_ENTRY) ? '0 : sweep_q + 1'b1;
      end
    end
  end

  // One write port: a data byte on commit, otherwise one fill entry per sweep cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && res_d.ram_written) begin
      ram_q[ac_q[AW-1:0]] <= res_d.ram_write_char;
    end else if (ctrl_i.sweep_step) begin
      ram_q[sweep_q] <= fill_q;
    end
  end

  assign stat_o.clear_hit  = clear_hit;
  assign stat_o.sweep_last = (sweep_q == LAST_ENTRY);
  assign res_o             = res_q;

endmodule

FILE: sv/clcd_ctrl.sv
// Controller: sequences capture, execution, result hand-off and RAM fill sweeps.
module clcd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_ready_i,
  input  clcd_pkg::stat_t stat_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output clcd_pkg::ctrl_t ctrl_o
);
  import clcd_pkg::*;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } ctl_state_e;

  ctl_state_e state_q;
  logic       in_ready_q;
  logic       out_valid_q;

  assign ctrl_o.capture    = in_valid_i && in_ready_q;
  // The result register is free when empty or when its beat is taken now.
  assign ctrl_o.commit     = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign ctrl_o.sweep_step = (state_q == S_SWEEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_SWEEP: begin
          if (stat_i.sweep_last) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        S_IDLE: begin
          if (ctrl_o.capture) begin
            state_q    <= S_EXEC;
            in_ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          if (ctrl_o.commit) begin
            if (stat_i.clear_hit) begin
              state_q <= S_SWEEP;
            end else begin
              state_q    <= S_IDLE;
              in_ready_q <= 1'b1;
            end
          end
        end
        default: begin
          state_q    <= S_SWEEP;
          in_ready_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/clcd_checker.sv
// Port-level checker for the character LCD controller and its bind statement.
`include "char_lcd_controller_4bit_macros.svh"

module clcd_checker #(
  parameter int RAM_DEPTH = 80
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic [2:0] status_i,
  input logic       ram_written_i,
  input logic [6:0] ram_write_address_i,
  input logic [7:0] ram_write_char_i,
  input logic [6:0] address_counter_now_i
);
  import clcd_pkg::*;

  localparam logic [7:0] DEPTH8 = 8'(RAM_DEPTH);

  // One access in flight: an accepted beat drops ready for the next cycle.
  `CLCD_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // A RAM write only happens on a clean data byte.
  `CLCD_ASSERT_IMPL(a_write_ok, clk_i, rst_ni, out_valid_i && ram_written_i, status_i == ST_OK)

  // Without a RAM write the write fields read as zero.
  `CLCD_ASSERT_IMPL(a_write_fields_zero, clk_i, rst_ni, out_valid_i && !ram_written_i,
    ram_write_address_i == 7'd0 && ram_write_char_i == 8'd0)

  // The address counter never leaves the display RAM.
  `CLCD_ASSERT_IMPL(a_ac_in_range, clk_i, rst_ni, out_valid_i,
    8'(address_counter_now_i) < DEPTH8)

endmodule

bind char_lcd_controller_4bit clcd_checker #(
  .RAM_DEPTH (RAM_DEPTH)
) u_clcd_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_i.valid),
  .in_ready_i            (in_i.ready),
  .out_valid_i           (out_o.valid),
  .status_i              (out_o.status),
  .ram_written_i         (out_o.ram_written),
  .ram_write_address_i   (out_o.ram_write_address),
  .ram_write_char_i      (out_o.ram_write_char),
  .address_counter_now_i (out_o.address_counter_now)
);

FILE: tb/char_lcd_controller_4bit_tb.sv
// Self-checking testbench for the 4-bit character LCD controller.
`timescale 1ns / 100ps

module char_lcd_controller_4bit_tb;
  import clcd_pkg::*;

  localparam int          RAM_DEPTH  = 80;
  localparam int          NUM_ITEMS  = 1700;
  localparam int          LIMIT      = 400000;
  localparam int          HOLD_AT    = 1200;
  localparam int          HOLD_LEN   = 150;
  localparam int          QUIET_LO   = 2500;
  localparam int          QUIET_HI   = 3500;
  localparam logic        CMD_READ   = ~CMD_LATCH;
  localparam logic [2:0]  PORT_SPARE = 3'd7;

  typedef struct packed {
    logic       cmd;
    logic [2:0] port;
    logic [7:0] bus;
  } access_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  clcd_in_if  in_if ();
  clcd_out_if out_if ();

  char_lcd_controller_4bit #(
    .RAM_DEPTH(RAM_DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #10 clk_i = ~clk_i;

  access_t access_q[$];
  result_t lcd_expect_q[$];
  logic    in_taken = 1'b0;
  int      cycle_cnt = 0;
  int      hold_left = 0;
  int      mismatches = 0;
  int      accesses = 0;
  int      results = 0;
  int      ram_writes = 0;
  int      error_statuses = 0;

  wire quiet_win = (cycle_cnt >= QUIET_LO) && (cycle_cnt < QUIET_HI);

  // Shadow copy of the controller state.
  logic [7:0] ins_reg = '0;
  logic [7:0] dat_reg = '0;
  logic       rs_q = 1'b0;
  logic       rw_q = 1'b0;
  logic       e_q = 1'b0;
  logic [6:0] ac_q = '0;
  logic       two_line_q = 1'b0;
  logic       disp_q = 1'b0;
  logic       cur_q = 1'b0;
  logic       blink_q = 1'b0;
  logic       incr_q = 1'b0;
  logic       low_nib_q = 1'b0;
  logic [7:0] rst_cnt_q = '0;
  logic [2:0] busy_q = '0;

  // Applies one port access to the shadow state and returns its result beat.
  function automatic result_t lcd_step(input logic cmd, input logic [2:0] port,
                                       input logic [7:0] bus);
    result_t r;
    logic    rise;
    logic    bf;
    logic [7:0] ins;
    r = '0;
    if (cmd == CMD_LATCH) begin
      if (port == PORT_NULL) begin
        r.status = ST_OK;
      end else if (port != PORT_LCD) begin
        r.status = ST_BAD_PORT;
      end else begin
        rise = !e_q && bus[5];
        rs_q = bus[7];
        rw_q = bus[6];
        e_q  = bus[5];
        if (rs_q && rw_q) begin
          r.status = ST_DATA_READ;
        end else if (rise) begin
          if (rs_q) begin
            dat_reg = low_nib_q ? {dat_reg[7:4], bus[3:0]} : {bus[3:0], dat_reg[3:0]};
          end else if (!rw_q) begin
            ins_reg = low_nib_q ? {ins_reg[7:4], bus[3:0]} : {bus[3:0], ins_reg[3:0]};
          end
          low_nib_q = !low_nib_q;
          if (!low_nib_q) begin
            if (rs_q) begin
              r.ram_written       = 1'b1;
              r.ram_write_address = ac_q;
              r.ram_write_char    = dat_reg;
              if (incr_q) begin
                ac_q = (ac_q == RAM_DEPTH - 1) ? 7'd0 : ac_q + 7'd1;
              end else begin
                ac_q = (ac_q == 7'd0) ? 7'd0 : ac_q - 7'd1;
              end
              busy_q = 3'd1;
            end else if (rw_q) begin
              if (busy_q != 3'd0) busy_q = busy_q - 3'd1;
            end else begin
              ins = ins_reg;
              if (ins == INS_RESET_START) begin
                if (rst_cnt_q != 8'hFF) rst_cnt_q = rst_cnt_q + 8'd1;
              end else if (ins == INS_RESET_END) begin
                if (rst_cnt_q != 8'd1 || busy_q != 3'd0) begin
                  r.status = ST_RESET_ORDER;
                end else begin
                  rst_cnt_q = '0;
                  busy_q    = 3'd4;
                end
              end else if ((ins & MSK_FUNC_SET) == VAL_FUNC_SET) begin
                if (ins[4]) begin
                  r.status = ST_EIGHT_BIT;
                end else begin
                  two_line_q = ins[3];
                  busy_q     = 3'd3;
                end
              end else if ((ins & MSK_DISP_CTRL) == VAL_DISP_CTRL) begin
                disp_q  = ins[2];
                cur_q   = ins[1];
                blink_q = ins[0];
                busy_q  = 3'd1;
              end else if ((ins & MSK_HOME) == VAL_HOME) begin
                ac_q   = '0;
                busy_q = 3'd5;
              end else if (ins == INS_CLEAR) begin
                ac_q   = '0;
                incr_q = 1'b1;
                busy_q = 3'd5;
              end else if ((ins & MSK_SET_ADDR) == VAL_SET_ADDR) begin
                ac_q   = ((ins & SET_ADDR_BITS) < RAM_DEPTH) ? ins[6:0] & 7'h3F : 7'd0;
                busy_q = 3'd2;
              end else begin
                r.status = ST_BAD_INSTR;
              end
            end
          end
        end
      end
    end else begin
      if (port != PORT_LCD) begin
        r.status = ST_BAD_PORT;
      end else if (!e_q) begin
        r.read_data = READ_IDLE;
      end else if (!rw_q) begin
        r.status = ST_NO_RW;
      end else if (rs_q) begin
        r.status = ST_DATA_READ;
      end else begin
        bf = (busy_q != 3'd0);
        r.read_data = low_nib_q ? {bf, 3'b000, bf, ac_q[6:4]} : {4'h0, ac_q[3:0]};
      end
    end
    r.address_counter_now = ac_q;
    r.busy_now            = busy_q;
    r.display_enabled     = disp_q;
    r.cursor_enabled      = cur_q;
    r.blink_enabled       = blink_q;
    r.two_line_mode       = two_line_q;
    r.entry_increments    = incr_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Port byte with the given control lines; the unused bit 4 is random.
  function automatic logic [7:0] lcd_bus(input logic rs, input logic rw, input logic e,
                                         input logic [3:0] nib);
    return {rs, rw, e, 1'($urandom_range(1)), nib};
  endfunction

  task automatic push_access(input logic cmd, input logic [2:0] port, input logic [7:0] bus);
    access_t a;
    a.cmd  = cmd;
    a.port = port;
    a.bus  = bus;
    access_q.push_back(a);
  endtask

  // Sends a whole instruction (rs low) or data byte (rs high), high nibble first.
  task automatic push_byte(input logic rs, input logic [7:0] b);
    push_access(CMD_LATCH, PORT_LCD, lcd_bus(rs, 1'b0, 1'b0, b[7:4]));
    push_access(CMD_LATCH, PORT_LCD, lcd_bus(rs, 1'b0, 1'b1, b[7:4]));
    push_access(CMD_LATCH, PORT_LCD, lcd_bus(rs, 1'b0, 1'b0, b[3:0]));
    push_access(CMD_LATCH, PORT_LCD, lcd_bus(rs, 1'b0, 1'b1, b[3:0]));
  endtask

  // Busy flag and address read: one E pulse and one port read per nibble.
  task automatic push_status_read();
    repeat (2) begin
      push_access(CMD_LATCH, PORT_LCD, lcd_bus(1'b0, 1'b1, 1'b0, 4'($urandom_range(15))));
      push_access(CMD_LATCH, PORT_LCD, lcd_bus(1'b0, 1'b1, 1'b1, 4'($urandom_range(15))));
      push_access(CMD_READ, PORT_LCD, 8'($urandom_range(255)));
    end
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Input driver: holds an offered beat until it is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.command     <= CMD_LATCH;
      in_if.port_number <= '0;
      in_if.bus_byte    <= '0;
    end else if (!(in_if.valid && !in_taken)) begin
      if (access_q.size() != 0 && (quiet_win || $urandom_range(99) >= 21)) begin
        in_if.valid       <= 1'b1;
        in_if.command     <= access_q[0].cmd;
        in_if.port_number <= access_q[0].port;
        in_if.bus_byte    <= access_q[0].bus;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls plus one long hold-off so the block backs up.
  always @(negedge clk_i) begin
    if (cycle_cnt == HOLD_AT) hold_left = HOLD_LEN;
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= quiet_win || ($urandom_range(99) >= 21);
    end
  end

  // Monitor: predicts each accepted access and checks each result beat.
  always @(posedge clk_i) begin
    result_t want;
    in_taken <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      lcd_expect_q.push_back(lcd_step(in_if.command, in_if.port_number, in_if.bus_byte));
      void'(access_q.pop_front());
      accesses++;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (lcd_expect_q.size() == 0) begin
        $error("result beat with no access pending");
        mismatches++;
      end else begin
        want = lcd_expect_q.pop_front();
        results++;
        if (want.ram_written) ram_writes++;
        if (want.status != ST_OK) error_statuses++;
        check_field("read_data", want.read_data, out_if.read_data);
        check_field("status", want.status, out_if.status);
        check_field("ram_written", want.ram_written, out_if.ram_written);
        check_field("ram_write_address", want.ram_write_address, out_if.ram_write_address);
        check_field("ram_write_char", want.ram_write_char, out_if.ram_write_char);
        check_field("address_counter_now", want.address_counter_now,
                    out_if.address_counter_now);
        check_field("busy_now", want.busy_now, out_if.busy_now);
        check_field("display_enabled", want.display_enabled, out_if.display_enabled);
        check_field("cursor_enabled", want.cursor_enabled, out_if.cursor_enabled);
        check_field("blink_enabled", want.blink_enabled, out_if.blink_enabled);
        check_field("two_line_mode", want.two_line_mode, out_if.two_line_mode);
        check_field("entry_increments", want.entry_increments, out_if.entry_increments);
      end
    end
  end

  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    int         pick;
    logic [7:0] ins;

    // Directed opening: port errors, idle read, reset handshake, a read with RW low,
    // busy read, data reads, a data write below address zero and a clear.
    push_access(CMD_LATCH, PORT_SPARE, 8'hFF);
    push_access(CMD_LATCH, PORT_NULL, 8'hA5);
    push_access(CMD_READ, PORT_SPARE, 8'h00);
    push_access(CMD_READ, PORT_LCD, 8'h00);
    push_byte(1'b0, INS_RESET_START);
    push_byte(1'b0, INS_RESET_END);
    push_access(CMD_READ, PORT_LCD, 8'h00);
    push_status_read();
    push_access(CMD_LATCH, PORT_LCD, lcd_bus(1'b1, 1'b1, 1'b1, 4'hF));
    push_access(CMD_READ, PORT_LCD, 8'hFF);
    push_byte(1'b1, 8'hFF);
    push_byte(1'b0, INS_CLEAR);

    // Mostly well-formed instruction, data and busy-read sequences, some noise.
    while (access_q.size() < NUM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        case ($urandom_range(9))
          0:       ins = $urandom_range(1) ? INS_RESET_START : INS_RESET_END;
          1, 2:    ins = VAL_FUNC_SET | 8'($urandom_range(31));
          3, 4:    ins = VAL_DISP_CTRL | 8'($urandom_range(7));
          5:       ins = VAL_HOME | 8'($urandom_range(1));
          6:       ins = ($urandom_range(2) == 0) ? INS_CLEAR
                                                  : VAL_SET_ADDR | 8'($urandom_range(63));
          7:       ins = VAL_SET_ADDR | 8'($urandom_range(63));
          default: ins = 8'($urandom_range(255));
        endcase
        push_byte(1'b0, ins);
      end else if (pick < 70) begin
        push_byte(1'b1, 8'($urandom_range(255)));
      end else if (pick < 80) begin
        push_status_read();
      end else begin
        push_access(pick < 90 ? CMD_LATCH : CMD_READ,
                    ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : PORT_LCD,
                    8'($urandom_range(255)));
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (access_q.size() != 0 || in_if.valid) @(posedge clk_i);
    while (lcd_expect_q.size() != 0) @(posedge clk_i);
    repeat (2 * RAM_DEPTH) @(posedge clk_i);

    $display("Drove %0d port accesses and checked %0d results: %0d display RAM writes,",
             accesses, results, ram_writes);
    $display("%0d error statuses, with one long output hold-off.", error_statuses);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
